// ===== hw/rtl/buddy_block_allocator_top_assert.svh =====
// ---------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bba assertion failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bba assertion failed");

`endif

// ===== hw/rtl/bba_pkg.sv =====
// ---------------------------------------------------------------------------
// Buddy block allocator package
// Types, codes and defaults shared by the allocator files.
// ---------------------------------------------------------------------------
package bba_pkg;

   localparam int MAX_LEVELS_DEF = 6;
   localparam int ID_BITS_DEF    = 16;
   localparam logic [4:0] MIN_LOG2_CAP = 5'd20;
   localparam logic [4:0] MIN_LOG2_RST = 5'd5;
   localparam logic [2:0] LEVELS_RST   = 3'd5;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ABSENT = 2'd0;
   localparam kind_type KIND_FREE   = 2'd1;
   localparam kind_type KIND_USED   = 2'd2;
   localparam kind_type KIND_SPLIT  = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_TOO_BIG  = 2'd1;
   localparam status_type ST_NO_FREE  = 2'd2;
   localparam status_type ST_NO_ID    = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic CSR_MIN_LOG2 = 1'b0;
   localparam logic CSR_LEVELS   = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] process_id;
      logic [25:0] request_size;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  granted_size_log2;
      logic [5:0]  block_index;
   } rsp_type;

endpackage

// ===== hw/rtl/bba_ram.sv =====
// ---------------------------------------------------------------------------
// Buddy block allocator RAM
// Generic single write, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/buddy_block_allocator_top.sv =====
// Sequence: an error beat found in S_PREP goes on through S_FIN to the response; otherwise
//   the depth-first walk reads and evaluates each tree node visited, plus split and merge writes.
// Throughput: one beat at a time; the node memory, read or written in turn, sets the walk.
// Reset (synchronous) and any csr write clear the node valid bits at once:
//   the tree returns to a single free root, no clearing sweep.
// ---------------------------------------------------------------------------
// Buddy block allocator top level
// Node tree held in one RAM, walked by a sequencer for allocate and free.
// ---------------------------------------------------------------------------
`include "buddy_block_allocator_top_assert.svh"

module buddy_block_allocator_top
   import bba_pkg::*;
#(
   parameter int MAX_LEVELS = MAX_LEVELS_DEF,
   parameter int ID_BITS    = ID_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [4:0] csr_data
);

   localparam int NODES  = (1 << (MAX_LEVELS + 1)) - 1;
   localparam int NODE_W = $clog2(NODES);
   localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
   localparam int OWN_W  = (ID_BITS < 16) ? ID_BITS : 16;
   localparam int BI_W   = (NODE_W > 6) ? NODE_W : 6;
   localparam int ENT_W  = 2 + OWN_W;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_READ, S_EVAL, S_SPL_R, S_SPL_L, S_BACK,
      S_M_CHK, S_M_EVAL, S_M_L, S_M_R, S_M_P, S_FIN
   } state_type;

   state_type         state_ff;
   logic              op_ff;
   logic [OWN_W-1:0]  id_ff;
   logic [25:0]       size_ff;
   logic [4:0]        min_ff;
   logic [2:0]        lvl_cfg_ff;
   logic [NODE_W-1:0] idx_ff, res_idx_ff;
   logic [LVL_W-1:0]  d_ff, tgt_ff, res_d_ff;
   status_type        stat_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              valid_ff [NODES];
   logic              rd_valid_ff, rd_root_ff;

   logic              wr_en, rd_en;
   logic [NODE_W-1:0] wr_addr, rd_addr;
   logic [ENT_W-1:0]  wr_data, rd_data;

   logic [4:0]        mlog;
   logic [LVL_W-1:0]  lvl;
   logic              k_found;
   logic [LVL_W-1:0]  k_val;
   kind_type          q_kind;
   logic [OWN_W-1:0]  q_owner;
   logic [NODE_W-1:0] child_l, child_r, parent, buddy;
   logic [NODE_W-1:0] base, pos;
   logic [BI_W-1:0]   shifted;
   logic              req_fire, csr_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   assign mlog = (min_ff > MIN_LOG2_CAP) ? MIN_LOG2_CAP : min_ff;
   assign lvl  = (int'(lvl_cfg_ff) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS) : LVL_W'(lvl_cfg_ff);

   always_comb begin
      logic [5:0] s;
      k_found = 1'b0;
      k_val   = '0;
      for (int j = MAX_LEVELS; j >= 0; j--) begin
         s = 6'(mlog) + 6'(j);
         if ((LVL_W'(j) <= lvl) && (33'(size_ff) <= (33'd1 << s))) begin
            k_found = 1'b1;
            k_val   = LVL_W'(j);
         end
      end
   end

   assign q_kind  = rd_valid_ff ? rd_data[ENT_W-1 -: 2] : (rd_root_ff ? KIND_FREE : KIND_ABSENT);
   assign q_owner = rd_valid_ff ? rd_data[OWN_W-1:0] : '0;

   assign child_l = {idx_ff[NODE_W-2:0], 1'b1};
   assign child_r = child_l + NODE_W'(1);
   assign parent  = NODE_W'((idx_ff - NODE_W'(1)) >> 1);
   assign buddy   = idx_ff[0] ? (idx_ff + NODE_W'(1)) : (idx_ff - NODE_W'(1));
   assign base    = (NODE_W'(1) << res_d_ff) - NODE_W'(1);
   assign pos     = res_idx_ff - base;
   assign shifted = BI_W'(pos) << (lvl - res_d_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = {KIND_ABSENT, {OWN_W{1'b0}}};
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      case (state_ff)
         S_READ: rd_en = 1'b1;
         S_EVAL: begin
            if (op_ff == OP_ALLOC && q_kind == KIND_FREE) begin
               wr_en   = 1'b1;
               wr_data = (d_ff == tgt_ff) ? {KIND_USED, id_ff} : {KIND_SPLIT, {OWN_W{1'b0}}};
            end else if (op_ff == OP_FREE && q_kind == KIND_USED && q_owner == id_ff) begin
               wr_en   = 1'b1;
               wr_data = {KIND_FREE, {OWN_W{1'b0}}};
            end
         end
         S_SPL_R: begin
            wr_en   = 1'b1;
            wr_addr = child_r;
            wr_data = {KIND_FREE, {OWN_W{1'b0}}};
         end
         S_SPL_L: begin
            wr_en   = 1'b1;
            wr_data = (d_ff == tgt_ff) ? {KIND_USED, id_ff} : {KIND_SPLIT, {OWN_W{1'b0}}};
         end
         S_M_CHK: begin
            rd_en   = (idx_ff != '0);
            rd_addr = buddy;
         end
         S_M_L: begin
            wr_en   = 1'b1;
            wr_addr = {parent[NODE_W-2:0], 1'b1};
         end
         S_M_R: begin
            wr_en   = 1'b1;
            wr_addr = {parent[NODE_W-2:0], 1'b1} + NODE_W'(1);
         end
         S_M_P: begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = {KIND_FREE, {OWN_W{1'b0}}};
         end
         default: ;
      endcase
   end

   bba_ram #(.WIDTH(ENT_W), .DEPTH(NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         rd_root_ff  <= (rd_addr == '0);
      end
      if (reset || csr_fire) begin
         for (int i = 0; i < NODES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         min_ff       <= MIN_LOG2_RST;
         lvl_cfg_ff   <= LEVELS_RST;
      end else begin
         if (csr_fire) begin
            if (csr_index == CSR_MIN_LOG2) begin
               min_ff <= csr_data;
            end else begin
               lvl_cfg_ff <= csr_data[2:0];
            end
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_data.operation;
                  id_ff    <= req_data.process_id[OWN_W-1:0];
                  size_ff  <= req_data.request_size;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               idx_ff <= '0;
               d_ff   <= '0;
               tgt_ff <= lvl - k_val;
               if (id_ff == '0) begin
                  stat_ff  <= ST_NO_ID;
                  state_ff <= S_FIN;
               end else if (op_ff == OP_ALLOC && !k_found) begin
                  stat_ff  <= ST_TOO_BIG;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_EVAL;
            S_EVAL: begin
               if (op_ff == OP_ALLOC) begin
                  if (q_kind == KIND_FREE && d_ff == tgt_ff) begin
                     stat_ff    <= ST_OK;
                     res_idx_ff <= idx_ff;
                     res_d_ff   <= d_ff;
                     state_ff   <= S_FIN;
                  end else if (q_kind == KIND_FREE) begin
                     state_ff <= S_SPL_R;
                  end else if (q_kind == KIND_SPLIT && d_ff < tgt_ff) begin
                     idx_ff   <= child_l;
                     d_ff     <= d_ff + LVL_W'(1);
                     state_ff <= S_READ;
                  end else begin
                     state_ff <= S_BACK;
                  end
               end else begin
                  if (q_kind == KIND_USED && q_owner == id_ff) begin
                     stat_ff    <= ST_OK;
                     res_idx_ff <= idx_ff;
                     res_d_ff   <= d_ff;
                     state_ff   <= S_M_CHK;
                  end else if (q_kind == KIND_SPLIT && int'(d_ff) < MAX_LEVELS) begin
                     idx_ff   <= child_l;
                     d_ff     <= d_ff + LVL_W'(1);
                     state_ff <= S_READ;
                  end else begin
                     state_ff <= S_BACK;
                  end
               end
            end
            S_SPL_R: begin
               idx_ff   <= child_l;
               d_ff     <= d_ff + LVL_W'(1);
               state_ff <= S_SPL_L;
            end
            S_SPL_L: begin
               if (d_ff == tgt_ff) begin
                  stat_ff    <= ST_OK;
                  res_idx_ff <= idx_ff;
                  res_d_ff   <= d_ff;
                  state_ff   <= S_FIN;
               end else begin
                  state_ff <= S_SPL_R;
               end
            end
            S_BACK: begin
               if (idx_ff == '0) begin
                  stat_ff  <= (op_ff == OP_ALLOC) ? ST_NO_FREE : ST_NO_ID;
                  state_ff <= S_FIN;
               end else if (idx_ff[0]) begin
                  idx_ff   <= idx_ff + NODE_W'(1);
                  state_ff <= S_READ;
               end else begin
                  idx_ff <= parent;
                  d_ff   <= d_ff - LVL_W'(1);
               end
            end
            S_M_CHK:  state_ff <= (idx_ff == '0) ? S_FIN : S_M_EVAL;
            S_M_EVAL: state_ff <= (q_kind == KIND_FREE) ? S_M_L : S_FIN;
            S_M_L:    state_ff <= S_M_R;
            S_M_R:    state_ff <= S_M_P;
            S_M_P: begin
               idx_ff   <= parent;
               state_ff <= S_M_CHK;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.status <= stat_ff;
                  if (stat_ff == ST_OK) begin
                     rsp_ff.granted_size_log2 <= 5'(mlog + 5'(lvl) - 5'(res_d_ff));
                     rsp_ff.block_index       <= shifted[5:0];
                  end else begin
                     rsp_ff.granted_size_log2 <= '0;
                     rsp_ff.block_index       <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BBA_ASSERT_NOW(a_no_rw_clash, wr_en, !rd_en)
   `BBA_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_ready)
   `BBA_ASSERT_NOW(a_err_zero, rsp_valid && rsp_data.status != ST_OK,
                   rsp_data.granted_size_log2 == '0 && rsp_data.block_index == '0)
   `BBA_ASSERT_NOW(a_depth_bound, state_ff == S_EVAL && op_ff == OP_ALLOC, d_ff <= tgt_ff)

endmodule
